// File: src/nearest_point_search_3d_defines.svh
// Assertion macros shared by the nearest-point search block.
`ifndef NEAREST_POINT_SEARCH_3D_DEFINES_SVH
`define NEAREST_POINT_SEARCH_3D_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NPS3D_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define NPS3D_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: src/nps3d_pkg.sv
`timescale 1ns / 1ps
// Package with the constants and types of the nearest-point search block.
package nps3d_pkg;

    // Default table depth and coordinate width.
    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_COORD_BITS = 24;

    // Fixed field widths of the channels.
    localparam int POINT_INDEX_W = 8;
    localparam int RESULT_INDEX_W = 8;
    localparam int CFG_W = 9;

    // Item kinds carried in the input tuser.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

// File: src/nearest_point_search_3d.sv
`timescale 1ns / 1ps
// Top level of the nearest-point search block: point table, scan pipeline and sequencer.
//
//  channel | direction | handshake           | content
//  --------+-----------+---------------------+------------------------------------------
//  s_      | in        | s_tvalid / s_tready | load or query item, kind in tuser
//  m_      | out       | m_tvalid / m_tready | nearest index, empty flag in tuser
//  cfg_    | in        | cfg_valid/cfg_ready | points_in_use register
//
// A load is written to the table when it is taken. For a query, the table memory is read one
// entry per cycle over points_in_use entries (limited to MAX_POINTS), and each entry passes a
// four-stage distance and compare pipeline before the result is held. A query with no points
// in use skips the scan and goes straight to the done state.
// Reset is synchronous and active low; the table is not cleared by reset.
// Input items are taken only between queries; a result waiting at m_ stalls only the
// completion of the next query.
`include "nearest_point_search_3d_defines.svh"

module nearest_point_search_3d #(
    parameter int MAX_POINTS = nps3d_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = nps3d_pkg::DEF_COORD_BITS,
    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
    localparam int S_FIELDS_W = nps3d_pkg::POINT_INDEX_W + 3 * COORD_BITS,
    localparam int S_TDATA_W = ((S_FIELDS_W + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Input channel.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [S_TDATA_W-1:0]                 s_tdata,   // point_index, coord_x, coord_y, coord_z
    input  logic                                 s_tuser,   // kind
    // Result channel.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [nps3d_pkg::RESULT_INDEX_W-1:0] m_tdata,   // nearest_index
    output logic                                 m_tuser,   // table_empty
    // Configuration channel.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nps3d_pkg::CFG_W-1:0]          cfg_data
);

    localparam int C = COORD_BITS;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = 3 * C;
    localparam int MAG_W = C + 1;
    localparam int SQ_W = 2 * C + 2;
    localparam int SUM_W = 2 * C + 4;
    localparam int PI_W = nps3d_pkg::POINT_INDEX_W;

    nps3d_pkg::state_t state_reg, state_next;

    logic [nps3d_pkg::CFG_W-1:0] points_in_use_reg;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            issue_cnt_reg;
    logic [ENTRY_W-1:0]          query_reg;
    logic                        empty_reg;

    logic [ENTRY_W-1:0] point_mem [MAX_POINTS];
    logic [ENTRY_W-1:0] rd_data_reg;

    logic              v0_reg, v1_reg, v2_reg, v3_reg;
    logic [IDX_W-1:0]  idx0_reg, idx1_reg, idx2_reg, idx3_reg;
    logic [MAG_W-1:0]  mag_reg [3];
    logic [SQ_W-1:0]   sq_reg [3];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  best_dist_reg;
    logic [IDX_W-1:0]  best_idx_reg;

    logic                                 m_tvalid_reg;
    logic [nps3d_pkg::RESULT_INDEX_W-1:0] m_tdata_reg;
    logic                                 m_tuser_reg;

    logic             s_fire;
    logic             load_fire;
    logic             query_fire;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      n_clamped;
    logic             pipe_busy;
    logic             out_free;
    logic             issue_en;

    assign s_tready  = (state_reg == nps3d_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire     = s_tvalid && s_tready;
    assign load_fire  = s_fire && (s_tuser == nps3d_pkg::KIND_LOAD);
    assign query_fire = s_fire && (s_tuser == nps3d_pkg::KIND_QUERY);

    // Loads beyond the table depth are dropped.
    assign wr_addr = IDX_W'(s_tdata[PI_W-1:0]);
    assign mem_we  = load_fire && (32'(s_tdata[PI_W-1:0]) < 32'(MAX_POINTS));

    // Number of entries that a query scans, limited to the table depth.
    assign n_clamped = (32'(points_in_use_reg) > 32'(MAX_POINTS)) ?
                       32'(MAX_POINTS) : 32'(points_in_use_reg);

    assign pipe_busy = v0_reg || v1_reg || v2_reg || v3_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign issue_en  = (state_reg == nps3d_pkg::ST_SCAN);

    // Configuration register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_in_use_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            points_in_use_reg <= cfg_data;
        end
    end

    // Point table: one write port for loads, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            point_mem[wr_addr] <= s_tdata[PI_W +: ENTRY_W];
        end
        if (issue_en) begin
            rd_data_reg <= point_mem[issue_cnt_reg[IDX_W-1:0]];
        end
    end

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            nps3d_pkg::ST_IDLE: begin
                if (query_fire) begin
                    state_next = (n_clamped == 32'd0) ? nps3d_pkg::ST_DONE : nps3d_pkg::ST_SCAN;
                end
            end
            nps3d_pkg::ST_SCAN: begin
                if (issue_cnt_reg == n_reg - CNT_W'(1)) begin
                    state_next = nps3d_pkg::ST_DRAIN;
                end
            end
            nps3d_pkg::ST_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = nps3d_pkg::ST_DONE;
                end
            end
            nps3d_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = nps3d_pkg::ST_IDLE;
                end
            end
            default: state_next = nps3d_pkg::ST_IDLE;
        endcase
    end

    // Control registers of the sequencer and the pipeline valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= nps3d_pkg::ST_IDLE;
            issue_cnt_reg <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (query_fire) begin
                issue_cnt_reg <= '0;
            end else if (issue_en) begin
                issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
            end
            v0_reg <= issue_en;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Query capture.
    always_ff @(posedge aclk) begin
        if (query_fire) begin
            query_reg <= s_tdata[PI_W +: ENTRY_W];
            n_reg     <= CNT_W'(n_clamped);
            empty_reg <= (n_clamped == 32'd0);
        end
    end

    // Stage 1: per-axis difference and its magnitude.
    always_ff @(posedge aclk) begin
        logic signed [MAG_W-1:0] q_ext;
        logic signed [MAG_W-1:0] e_ext;
        logic signed [MAG_W-1:0] diff;
        idx0_reg <= issue_cnt_reg[IDX_W-1:0];
        idx1_reg <= idx0_reg;
        for (int c = 0; c < 3; c++) begin
            q_ext = $signed({query_reg[c*C + C - 1], query_reg[c*C +: C]});
            e_ext = $signed({rd_data_reg[c*C + C - 1], rd_data_reg[c*C +: C]});
            diff  = q_ext - e_ext;
            mag_reg[c] <= diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        end
    end

    // Stage 2: squares, one multiplier per axis.
    always_ff @(posedge aclk) begin
        idx2_reg <= idx1_reg;
        for (int c = 0; c < 3; c++) begin
            sq_reg[c] <= SQ_W'(mag_reg[c]) * SQ_W'(mag_reg[c]);
        end
    end

    // Stage 3: squared Euclidean distance.
    always_ff @(posedge aclk) begin
        idx3_reg <= idx2_reg;
        sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
    end

    // Stage 4: keep the first strict minimum; entry 0 always seeds the search.
    always_ff @(posedge aclk) begin
        if (query_fire) begin
            best_idx_reg <= '0;
        end else if (v3_reg && ((idx3_reg == '0) || (sum_reg < best_dist_reg))) begin
            best_dist_reg <= sum_reg;
            best_idx_reg  <= idx3_reg;
        end
    end

    // Result register; it holds until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((state_reg == nps3d_pkg::ST_DONE) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == nps3d_pkg::ST_DONE) && out_free) begin
            m_tdata_reg <= nps3d_pkg::RESULT_INDEX_W'(best_idx_reg);
            m_tuser_reg <= empty_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The table is never written while a query is in flight.
    `NPS3D_ASSERT_NOW(a_no_write_in_query, aclk, aresetn,
        state_reg != nps3d_pkg::ST_IDLE, !mem_we)
    // The result is only completed once the scan pipeline has drained.
    `NPS3D_ASSERT_NOW(a_done_after_drain, aclk, aresetn,
        state_reg == nps3d_pkg::ST_DONE, !pipe_busy)
    // Every distance compared belongs to an entry inside the scanned range.
    `NPS3D_ASSERT_NOW(a_index_in_range, aclk, aresetn,
        v3_reg, CNT_W'(idx3_reg) < n_reg)
    // An empty-table result always reports index zero.
    `NPS3D_ASSERT_NOW(a_empty_index_zero, aclk, aresetn,
        m_tvalid_reg && m_tuser_reg, m_tdata_reg == '0)
    // A query accepted with no points in use completes without a scan.
    `NPS3D_ASSERT_NEXT(a_empty_skips_scan, aclk, aresetn,
        query_fire && (n_clamped == 32'd0), state_reg == nps3d_pkg::ST_DONE)

endmodule
